### rtl/jordan_pivot_step_engine_macros.svh
// Assertion helpers shared by the RTL. Each use expects clk and arst_n in scope.
`ifndef JORDAN_PIVOT_STEP_ENGINE_MACROS_SVH
`define JORDAN_PIVOT_STEP_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JPSE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JPSE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/jpse_pkg.sv
`default_nettype none
package jpse_pkg;

	localparam int FUNC_W = 2;
	localparam int ROW_W  = 3;
	localparam int COL_W  = 4;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int CFG_W  = 4;
	// Loop counters and indexes; register values never exceed 15.
	localparam int IDX_W  = 4;
	// Quotient bits kept by the divider; larger quotients always saturate.
	localparam int QW     = 34;

	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOPIV = 2'd1;
	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_SAT   = 2'd3;

	localparam logic REG_NUM_ROWS = 1'b0;
	localparam logic REG_NUM_VARS = 1'b1;

	// Entry class: {in pivot row, in pivot column}.
	localparam logic [1:0] KIND_OTHER = 2'b00;
	localparam logic [1:0] KIND_COL   = 2'b01;
	localparam logic [1:0] KIND_ROW   = 2'b10;
	localparam logic [1:0] KIND_PIVOT = 2'b11;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             we;
		logic             we_res;
		logic             piv_cap;
		logic             rb_wr;
		logic             cb_wr;
		logic             mul;
		logic             prep;
		logic             div_start;
		logic             sgn;
		logic             sat_clr;
		logic             out_load;
		logic             out_rd;
		logic [1:0]       kind;
	} cmd_t;

	typedef struct packed {
		logic rd_nz;
		logic div_done;
		logic sat;
	} stat_t;

endpackage
`default_nettype wire

### rtl/jpse_ram.sv
`default_nettype none
module jpse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 72,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### rtl/jpse_div.sv
`default_nettype none
module jpse_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [63:0]           num,
	input  wire logic [32:0]           den,
	output logic                       done,
	output logic [jpse_pkg::QW-1:0]    quo,
	output logic                       ovf
);

	logic [63:0]             num_q;
	logic [32:0]             den_q;
	logic [32:0]             rem_q;
	logic [jpse_pkg::QW-1:0] quo_q;
	logic                    ovf_q;
	logic [5:0]              cnt_q;
	logic                    chk_q;
	logic                    busy_q;
	logic                    done_q;
	logic [32:0]             head;
	logic [32:0]             trial;
	logic                    ge;

	// Upper part of the numerator; it must stay below the divisor.
	assign head  = {3'b000, num_q[63:jpse_pkg::QW]};
	assign trial = {rem_q[31:0], num_q[jpse_pkg::QW-1]};
	assign ge    = trial >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q  <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			chk_q  <= 1'b1;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (chk_q) begin
			chk_q <= 1'b0;
			cnt_q <= 6'(jpse_pkg::QW);
			if (head >= den_q) begin
				done_q <= 1'b1;
			end else begin
				busy_q <= 1'b1;
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
		end else if (chk_q) begin
			ovf_q <= head >= den_q;
			rem_q <= head;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial - den_q : trial;
			quo_q <= {quo_q[jpse_pkg::QW-2:0], ge};
			num_q <= {num_q[62:0], 1'b0};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign ovf  = ovf_q;

endmodule
`default_nettype wire

### rtl/jpse_dpath.sv
`default_nettype none
module jpse_dpath #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_VARS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire jpse_pkg::cmd_t                cmd,
	input  wire logic [jpse_pkg::DATA_W-1:0]   in_value,
	output jpse_pkg::stat_t                    st,
	output logic [jpse_pkg::DATA_W-1:0]        read_value
);

	localparam int NCOLS = MAX_VARS + 1;
	localparam int DEPTH = MAX_ROWS * NCOLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RIW   = $clog2(MAX_ROWS);
	localparam int CIW   = $clog2(NCOLS);

	logic [AW-1:0]        addr;
	logic [31:0]          rdata;
	logic [31:0]          wdata;
	logic [31:0]          dmag_q;
	logic                 pneg_q;
	logic signed [31:0]   rowbuf_q [NCOLS];
	logic signed [31:0]   colbuf_q [MAX_ROWS];
	logic signed [31:0]   a_s1;
	logic signed [63:0]   prod_s1;
	logic [62:0]          n_s2;
	logic                 neg_s2;
	logic signed [35:0]   t_s3;
	logic                 ovf_s3;
	logic                 sat_q;
	logic [31:0]          out_q;
	logic [62:0]          n_d;
	logic                 nneg_d;
	logic [31:0]          absa;
	logic [63:0]          absp;
	logic                 div_done;
	logic [jpse_pkg::QW-1:0] quo;
	logic                 ovf;
	logic [35:0]          q_ext;
	logic signed [36:0]   v;
	logic [31:0]          res;
	logic                 res_sat;

	assign addr = AW'(AW'(cmd.row) * AW'(NCOLS)) + AW'(cmd.col);
	assign wdata = cmd.we_res ? res : in_value;

	jpse_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (cmd.we),
		.waddr (addr),
		.wdata (wdata),
		.raddr (addr),
		.rdata (rdata)
	);

	assign absa = a_s1[31] ? 32'(-a_s1) : 32'(a_s1);
	assign absp = prod_s1[63] ? 64'(-prod_s1) : 64'(prod_s1);

	// Magnitude and sign of the numerator for each class of entry.
	always_comb begin
		n_d    = absp[62:0];
		nneg_d = prod_s1[63];
		case (cmd.kind)
			jpse_pkg::KIND_PIVOT: begin
				n_d    = 63'(1) << 32;
				nneg_d = 1'b0;
			end
			jpse_pkg::KIND_ROW: begin
				n_d    = 63'(absa) << 16;
				nneg_d = a_s1[31];
			end
			jpse_pkg::KIND_COL: begin
				n_d    = 63'(absa) << 16;
				nneg_d = ~a_s1[31];
			end
			default: begin
				n_d    = absp[62:0];
				nneg_d = prod_s1[63];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.piv_cap) begin
			dmag_q <= rdata[31] ? 32'(-rdata) : rdata;
			pneg_q <= rdata[31];
		end
		if (cmd.rb_wr) begin
			rowbuf_q[CIW'(cmd.col)] <= rdata;
		end
		if (cmd.cb_wr) begin
			colbuf_q[RIW'(cmd.row)] <= rdata;
		end
		if (cmd.mul) begin
			a_s1    <= rdata;
			prod_s1 <= rowbuf_q[CIW'(cmd.col)] * colbuf_q[RIW'(cmd.row)];
		end
		if (cmd.prep) begin
			n_s2   <= n_d;
			neg_s2 <= nneg_d ^ pneg_q;
		end
		if (cmd.sgn) begin
			t_s3   <= neg_s2 ? -$signed(q_ext) : $signed(q_ext);
			ovf_s3 <= ovf;
		end
		if (cmd.out_load) begin
			out_q <= cmd.out_rd ? rdata : '0;
		end
	end

	// Rounded quotient: floor((2n + d) / 2d).
	jpse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    ({n_s2, 1'b0} + {32'd0, dmag_q}),
		.den    ({dmag_q, 1'b0}),
		.done   (div_done),
		.quo    (quo),
		.ovf    (ovf)
	);

	assign q_ext = {2'b00, quo};

	always_comb begin
		if (cmd.kind == jpse_pkg::KIND_OTHER) begin
			v = {{5{a_s1[31]}}, a_s1} - {t_s3[35], t_s3};
		end else begin
			v = {t_s3[35], t_s3};
		end
		res_sat = 1'b0;
		res     = v[31:0];
		if (ovf_s3) begin
			res_sat = 1'b1;
			res = ((cmd.kind == jpse_pkg::KIND_OTHER) == neg_s2) ? 32'h7FFF_FFFF
				: 32'h8000_0000;
		end else if (v[36:31] != {6{v[36]}}) begin
			res_sat = 1'b1;
			res = v[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (cmd.sat_clr) begin
			sat_q <= 1'b0;
		end else if (cmd.we && cmd.we_res && res_sat) begin
			sat_q <= 1'b1;
		end
	end

	assign st.rd_nz    = rdata != 32'd0;
	assign st.div_done = div_done;
	assign st.sat      = sat_q;
	assign read_value  = out_q;

endmodule
`default_nettype wire

### rtl/jpse_ctrl.sv
`default_nettype none
`include "jordan_pivot_step_engine_macros.svh"
module jpse_ctrl #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_VARS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_valid,
	output logic                               s_ready,
	input  wire logic [jpse_pkg::FUNC_W-1:0]   in_func,
	input  wire logic [jpse_pkg::ROW_W-1:0]    in_row,
	input  wire logic [jpse_pkg::COL_W-1:0]    in_col,
	output logic                               m_valid,
	input  wire logic                          m_ready,
	output logic [jpse_pkg::COL_W-1:0]         pivot_col,
	output logic [jpse_pkg::STAT_W-1:0]        status,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_index,
	input  wire logic [jpse_pkg::CFG_W-1:0]    cfg_data,
	output jpse_pkg::cmd_t                     cmd,
	input  wire jpse_pkg::stat_t               st
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SCAN_RD = 4'd1;
	localparam logic [3:0] S_SCAN_CK = 4'd2;
	localparam logic [3:0] S_LR_RD   = 4'd3;
	localparam logic [3:0] S_LR_WR   = 4'd4;
	localparam logic [3:0] S_LC_RD   = 4'd5;
	localparam logic [3:0] S_LC_WR   = 4'd6;
	localparam logic [3:0] S_E_RD    = 4'd7;
	localparam logic [3:0] S_E_MUL   = 4'd8;
	localparam logic [3:0] S_E_PREP  = 4'd9;
	localparam logic [3:0] S_E_LOAD  = 4'd10;
	localparam logic [3:0] S_E_DIV   = 4'd11;
	localparam logic [3:0] S_E_SGN   = 4'd12;
	localparam logic [3:0] S_E_FIN   = 4'd13;
	localparam logic [3:0] S_OUT     = 4'd14;

	localparam int IW = jpse_pkg::IDX_W;

	logic [3:0]                   state_q;
	logic [IW-1:0]                rows_q, vars_q, nr, nv;
	logic [IW-1:0]                step_q, r_q, s_q, i_q, j_q;
	logic [jpse_pkg::FUNC_W-1:0]  func_q;
	logic [IW-1:0]                row_q;
	logic [jpse_pkg::COL_W-1:0]   col_q;
	logic                         inside_q, found_q;
	logic [jpse_pkg::COL_W-1:0]   pcol_q, pcol_out_q;
	logic [jpse_pkg::STAT_W-1:0]  rstat_q, stat_out_q;
	logic                         m_valid_q;
	logic                         acc, in_ok, last_i, last_j, out_free;

	// Register values outside 1..MAX are clamped where they are used.
	always_comb begin
		nr = rows_q;
		if (rows_q == '0) begin
			nr = IW'(1);
		end else if ({1'b0, rows_q} > (IW + 1)'(MAX_ROWS)) begin
			nr = IW'(MAX_ROWS);
		end
		nv = vars_q;
		if (vars_q == '0) begin
			nv = IW'(1);
		end else if ({1'b0, vars_q} > (IW + 1)'(MAX_VARS)) begin
			nv = IW'(MAX_VARS);
		end
	end

	assign s_ready  = state_q == S_IDLE;
	assign acc      = s_valid && s_ready;
	assign in_ok    = ({1'b0, in_row} < nr) && (in_col <= nv);
	assign last_i   = i_q == nr - IW'(1);
	assign last_j   = j_q == nv;
	assign out_free = !m_valid_q || m_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rows_q    <= IW'(2);
			vars_q    <= IW'(3);
			step_q    <= '0;
			r_q       <= '0;
			s_q       <= '0;
			i_q       <= '0;
			j_q       <= '0;
			func_q    <= jpse_pkg::FUNC_WRITE;
			row_q     <= '0;
			col_q     <= '0;
			inside_q  <= 1'b0;
			found_q   <= 1'b0;
			pcol_q    <= '0;
			rstat_q   <= jpse_pkg::STAT_OK;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					jpse_pkg::REG_NUM_ROWS: rows_q <= cfg_data;
					jpse_pkg::REG_NUM_VARS: vars_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						func_q   <= in_func;
						row_q    <= {1'b0, in_row};
						col_q    <= in_col;
						inside_q <= in_ok;
						found_q  <= 1'b0;
						pcol_q   <= '0;
						rstat_q  <= jpse_pkg::STAT_OK;
						state_q  <= S_OUT;
						if (in_func == jpse_pkg::FUNC_STEP) begin
							if (step_q >= nr) begin
								rstat_q <= jpse_pkg::STAT_DONE;
							end else begin
								r_q     <= step_q;
								s_q     <= step_q;
								step_q  <= step_q + IW'(1);
								state_q <= S_SCAN_RD;
							end
						end
					end
				end
				S_SCAN_RD: begin
					if (s_q > nv) begin
						rstat_q <= jpse_pkg::STAT_NOPIV;
						state_q <= S_OUT;
					end else begin
						state_q <= S_SCAN_CK;
					end
				end
				S_SCAN_CK: begin
					if (st.rd_nz) begin
						found_q <= 1'b1;
						pcol_q  <= s_q;
						j_q     <= '0;
						state_q <= S_LR_RD;
					end else if (s_q == nv) begin
						rstat_q <= jpse_pkg::STAT_NOPIV;
						state_q <= S_OUT;
					end else begin
						s_q     <= s_q + IW'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_LR_RD: state_q <= S_LR_WR;
				S_LR_WR: begin
					if (last_j) begin
						i_q     <= '0;
						state_q <= S_LC_RD;
					end else begin
						j_q     <= j_q + IW'(1);
						state_q <= S_LR_RD;
					end
				end
				S_LC_RD: state_q <= S_LC_WR;
				S_LC_WR: begin
					if (last_i) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= S_E_RD;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_LC_RD;
					end
				end
				S_E_RD:   state_q <= S_E_MUL;
				S_E_MUL:  state_q <= S_E_PREP;
				S_E_PREP: state_q <= S_E_LOAD;
				S_E_LOAD: state_q <= S_E_DIV;
				S_E_DIV: begin
					if (st.div_done) begin
						state_q <= S_E_SGN;
					end
				end
				S_E_SGN: state_q <= S_E_FIN;
				S_E_FIN: begin
					if (last_j) begin
						j_q <= '0;
						if (last_i) begin
							state_q <= S_OUT;
						end else begin
							i_q     <= i_q + IW'(1);
							state_q <= S_E_RD;
						end
					end else begin
						j_q     <= j_q + IW'(1);
						state_q <= S_E_RD;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			pcol_out_q <= pcol_q;
			stat_out_q <= (found_q && st.sat) ? jpse_pkg::STAT_SAT : rstat_q;
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.row       = i_q;
		cmd.col       = j_q;
		cmd.kind      = {i_q == r_q, j_q == s_q};
		case (state_q)
			S_IDLE: begin
				cmd.row     = {1'b0, in_row};
				cmd.col     = in_col;
				cmd.we      = acc && in_func == jpse_pkg::FUNC_WRITE && in_ok;
				cmd.sat_clr = acc && in_func == jpse_pkg::FUNC_STEP;
			end
			S_SCAN_RD: begin
				cmd.row = r_q;
				cmd.col = s_q;
			end
			S_SCAN_CK: begin
				cmd.row     = r_q;
				cmd.col     = s_q;
				cmd.piv_cap = st.rd_nz;
			end
			S_LR_RD: cmd.row = r_q;
			S_LR_WR: begin
				cmd.row   = r_q;
				cmd.rb_wr = 1'b1;
			end
			S_LC_RD: cmd.col = s_q;
			S_LC_WR: begin
				cmd.col   = s_q;
				cmd.cb_wr = 1'b1;
			end
			S_E_MUL:  cmd.mul = 1'b1;
			S_E_PREP: cmd.prep = 1'b1;
			S_E_LOAD: cmd.div_start = 1'b1;
			S_E_SGN:  cmd.sgn = 1'b1;
			S_E_FIN: begin
				cmd.we     = 1'b1;
				cmd.we_res = 1'b1;
			end
			S_OUT: begin
				cmd.row      = row_q;
				cmd.col      = col_q;
				cmd.out_load = out_free;
				cmd.out_rd   = func_q == jpse_pkg::FUNC_READ && inside_q;
			end
			default: ;
		endcase
	end

	assign m_valid   = m_valid_q;
	assign pivot_col = pcol_out_q;
	assign status    = stat_out_q;

	`JPSE_ASSERT_NXT(a_step_hold, !(acc && in_func == jpse_pkg::FUNC_STEP), step_q == $past(step_q), "step counter moved without a step")
	`JPSE_ASSERT_IMP(a_write_in_table, cmd.we, (cmd.row < nr) && (cmd.col <= nv), "table write outside the active area")
	`JPSE_ASSERT_IMP(a_scan_from_row, state_q == S_SCAN_CK, s_q >= r_q, "pivot scan left of the step column")

endmodule
`default_nettype wire

### rtl/jordan_pivot_step_engine.sv
`default_nettype none
// Modified Jordan elimination engine over a table of signed Q16.16 words.
// Input channel s_*: one transaction per command. tuser selects the command:
// write one table element, run the next pivot step, or read one element.
// Every accepted command yields exactly one result transaction on m_*.
// Configuration channel cfg_*: index 0 sets the row count, index 1 the
// number of unknowns; it is always ready. The user must write it only
// while idle; the block itself does not enforce this. A write or read
// passes through S_OUT, which loads the output register; the controller
// is idle and ready for the next command once the result is presented.
// A pivot step scans for the pivot column, buffers the pivot row and
// column, then updates each table entry in turn through the bit-serial
// rounding divider shared by all entries.
// One command is in flight at a time; s_tready is high only when idle.
// Reset clears the step counter and restores the register defaults; table
// contents are undefined until written. When m_tready is low the result
// holds in its output register; a further command can still be accepted,
// but its result waits in S_OUT until the output drains.
module jordan_pivot_step_engine #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_VARS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// row [2:0], col [6:3], value [38:7], zero [39]
	input  wire logic [39:0] s_tdata,
	// func [1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// read_value [31:0], pivot_col [35:32], zero [39:36]
	output logic [39:0]      m_tdata,
	// status [1:0]
	output logic [1:0]       m_tuser,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [3:0]  cfg_data
);

	jpse_pkg::cmd_t  cmd;
	jpse_pkg::stat_t st;
	logic [31:0]     read_value;
	logic [3:0]      pivot_col;

	// Configuration writes complete in the cycle they are offered.
	assign cfg_ready = 1'b1;

	// The controller sequences all commands; the datapath owns the table.
	jpse_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_VARS(MAX_VARS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_tvalid),
		.s_ready   (s_tready),
		.in_func   (s_tuser),
		.in_row    (s_tdata[2:0]),
		.in_col    (s_tdata[6:3]),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.pivot_col (pivot_col),
		.status    (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st)
	);

	jpse_dpath #(.MAX_ROWS(MAX_ROWS), .MAX_VARS(MAX_VARS)) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_value   (s_tdata[38:7]),
		.st         (st),
		.read_value (read_value)
	);

	assign m_tdata = {4'd0, pivot_col, read_value};

endmodule
`default_nettype wire
